@@ hdl/wet_pkg.sv @@
// wet_pkg: shared types and constants of the weighted edge table
// holds field widths, opcodes, status codes, the controller state type and
// the command and status bundles between controller and datapath
`default_nettype none

package wet_pkg;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int NODE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // parameter defaults
    localparam int NODE_COUNT_DEF  = 256;
    localparam int MAX_DEGREE_DEF  = 16;
    localparam int WEIGHT_BITS_DEF = 32;

    // opcodes (bit 1 set means lookup)
    localparam logic [OP_W-1:0] OP_ADD_REPLACE = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_ACCUM   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP      = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP_ALT  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SELF_LOOP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ROW_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DEG,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic check;
        logic deg_load;
        logic scan;
        logic hit;
        logic miss;
        logic publish;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic range_bad;
        logic self_add;
        logic hit;
        logic miss;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/wet_ctrl.sv @@
// wet_ctrl: sequencing state machine of the weighted edge table
// depends on wet_pkg for the state type and the command/status bundles
`default_nettype none

module wet_ctrl
    import wet_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.range_bad || i_stat.self_add) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DEG;
                end
            end
            S_DEG: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_HIT;
                end else if (i_stat.miss) begin
                    n_state = S_MISS;
                end
            end
            S_HIT: begin
                n_state = S_OUT;
            end
            S_MISS: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs; no word is taken while reset is held
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            S_DEG: begin
                o_cmd.deg_load = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_HIT: begin
                o_cmd.hit = 1'b1;
            end
            S_MISS: begin
                o_cmd.miss = 1'b1;
            end
            S_OUT: begin
                o_cmd.publish = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/wet_dpath.sv @@
// wet_dpath: edge slot memories, degree memory, row scan and weight arithmetic
// depends on wet_pkg; driven by wet_ctrl through t_dp_cmd, reports t_dp_stat
`default_nettype none

module wet_dpath
    import wet_pkg::*;
#(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int MAX_DEGREE  = MAX_DEGREE_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic signed [WORD_W-1:0]   i_cfg_wr_data,
    input  wire logic [OP_W-1:0]            i_opcode,
    input  wire logic [NODE_W-1:0]          i_source_node,
    input  wire logic [NODE_W-1:0]          i_target_node,
    input  wire logic signed [WORD_W-1:0]   i_edge_weight_in,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic signed [WORD_W-1:0]        o_weight_out,
    output logic                            o_found,
    output logic [STATUS_W-1:0]             o_status,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat
);

    // sizes
    localparam int NODE_SPAN = 1 << NODE_W;
    localparam int ROWS      = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
    localparam int SLOTS     = ROWS * MAX_DEGREE;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int WB        = WEIGHT_BITS;
    localparam int EW        = ((WB > WORD_W) ? WB : WORD_W) + 1;

    localparam logic [DEG_W-1:0]   DEG_FULL   = DEG_W'(MAX_DEGREE);
    localparam logic [SLOT_AW-1:0] ROW_STRIDE = SLOT_AW'(MAX_DEGREE);

    // saturation bounds
    localparam logic signed [WB-1:0] WMAX   = {1'b0, {(WB-1){1'b1}}};
    localparam logic signed [WB-1:0] WMIN   = {1'b1, {(WB-1){1'b0}}};
    localparam logic signed [EW-1:0] WMAX_E = {{(EW-WB+1){1'b0}}, {(WB-1){1'b1}}};
    localparam logic signed [EW-1:0] WMIN_E = ~WMAX_E;
    localparam logic signed [EW-1:0] OMAX_E = {{(EW-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [EW-1:0] OMIN_E = ~OMAX_E;

    // configuration
    logic signed [WORD_W-1:0] r_nfw;

    // captured word
    logic [OP_W-1:0]      r_op;
    logic [NODE_W-1:0]    r_src;
    logic [NODE_W-1:0]    r_tgt;
    logic signed [WB-1:0] r_w;

    // scan state
    logic [SLOT_AW-1:0]   r_base;
    logic [DEG_W-1:0]     r_deg;
    logic [DEG_W-1:0]     r_idx;
    logic [DEG_W-1:0]     r_rd_off;
    logic                 r_rd_pend;
    logic signed [WB-1:0] r_hit_w;
    logic [DEG_W-1:0]     r_hit_off;

    // pending result
    logic signed [EW-1:0]  r_res_w;
    logic                  r_res_found;
    logic [STATUS_W-1:0]   r_res_status;

    // output register
    logic                      r_out_valid;
    logic signed [WORD_W-1:0]  r_out_w;
    logic                      r_out_found;
    logic [STATUS_W-1:0]       r_out_status;

    // memories
    logic [NODE_W-1:0]    r_tgt_mem [SLOTS];
    logic signed [WB-1:0] r_wgt_mem [SLOTS];
    logic [NODE_W-1:0]    r_tgt_rd;
    logic signed [WB-1:0] r_wgt_rd;
    logic [DEG_W-1:0]     r_deg_mem [ROWS];
    logic [ROWS-1:0]      r_deg_vld;
    logic [DEG_W-1:0]     r_deg_rd;
    logic                 r_deg_rd_vld;

    // combinational
    logic                 is_lookup;
    logic                 is_accum;
    logic [ROW_W-1:0]     row;
    logic                 range_bad;
    logic                 self_add;
    logic [SLOT_AW-1:0]   rd_addr;
    logic                 hit;
    logic                 miss;
    logic signed [EW-1:0] in_ext;
    logic signed [EW-1:0] in_sat_e;
    logic signed [WB:0]   sum_e;
    logic signed [WB-1:0] sum_sat;
    logic signed [WB-1:0] new_w;
    logic signed [EW-1:0] out_sat_e;
    logic                 row_full;
    logic                 slot_we;
    logic [SLOT_AW-1:0]   slot_wa;
    logic signed [WB-1:0] slot_wd;
    logic                 deg_we;

    // opcode decode
    always_comb begin
        unique case (r_op) inside
            OP_ADD_REPLACE, OP_ADD_ACCUM: is_lookup = 1'b0;
            OP_LOOKUP, OP_LOOKUP_ALT:     is_lookup = 1'b1;
            default:                      is_lookup = 1'b1;
        endcase
    end
    assign is_accum = (r_op == OP_ADD_ACCUM);

    // node checks
    assign row       = r_src[ROW_W-1:0];
    assign range_bad = (32'(r_src) >= 32'(NODE_COUNT)) || (32'(r_tgt) >= 32'(NODE_COUNT));
    assign self_add  = !is_lookup && (r_src == r_tgt);
    assign row_full  = (r_deg == DEG_FULL);

    // scan compare: data read last cycle against the wanted target
    assign rd_addr = r_base + SLOT_AW'(r_idx);
    assign hit     = r_rd_pend && (r_tgt_rd == r_tgt);
    assign miss    = !r_rd_pend && (r_idx == r_deg);

    // input weight saturated into the stored range
    assign in_ext   = EW'(i_edge_weight_in);
    assign in_sat_e = (in_ext > WMAX_E) ? WMAX_E : ((in_ext < WMIN_E) ? WMIN_E : in_ext);

    // saturating accumulate
    assign sum_e   = (WB+1)'(r_hit_w) + (WB+1)'(r_w);
    assign sum_sat = (sum_e[WB] != sum_e[WB-1]) ? (sum_e[WB] ? WMIN : WMAX) : sum_e[WB-1:0];
    assign new_w   = is_accum ? sum_sat : r_w;

    // result clipped to the 32-bit output word
    assign out_sat_e = (r_res_w > OMAX_E) ? OMAX_E : ((r_res_w < OMIN_E) ? OMIN_E : r_res_w);

    // memory write selection: weight update on a hit, append on a miss
    assign slot_we = !is_lookup && (i_cmd.hit || (i_cmd.miss && !row_full));
    assign slot_wa = i_cmd.hit ? (r_base + SLOT_AW'(r_hit_off)) : (r_base + SLOT_AW'(r_deg));
    assign slot_wd = i_cmd.hit ? new_w : r_w;
    assign deg_we  = !is_lookup && i_cmd.miss && !row_full;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfw <= '0;
        end else if (i_cfg_wr_en) begin
            r_nfw <= i_cfg_wr_data;
        end
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_tgt_mem[slot_wa] <= r_tgt;
            r_wgt_mem[slot_wa] <= slot_wd;
        end
        r_tgt_rd <= r_tgt_mem[rd_addr];
        r_wgt_rd <= r_wgt_mem[rd_addr];
    end

    // degree memory
    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            r_deg_mem[row] <= DEG_W'(r_deg + 1'b1);
        end
        r_deg_rd <= r_deg_mem[row];
    end

    // degree valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_vld    <= '0;
            r_deg_rd_vld <= 1'b0;
        end else begin
            if (deg_we) begin
                r_deg_vld[row] <= 1'b1;
            end
            r_deg_rd_vld <= r_deg_vld[row];
        end
    end

    // word capture and row setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_src <= i_source_node;
            r_tgt <= i_target_node;
            r_w   <= in_sat_e[WB-1:0];
        end
        if (i_cmd.check) begin
            r_base <= SLOT_AW'(row) * ROW_STRIDE;
        end
    end

    // row scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.deg_load) begin
            r_deg     <= r_deg_rd_vld ? r_deg_rd : '0;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_idx != r_deg) begin
                r_idx     <= DEG_W'(r_idx + 1'b1);
                r_rd_off  <= r_idx;
                r_rd_pend <= 1'b1;
            end else begin
                r_rd_pend <= 1'b0;
            end
            if (hit) begin
                r_hit_w   <= r_wgt_rd;
                r_hit_off <= r_rd_off;
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_res_found <= 1'b0;
            if (range_bad) begin
                r_res_w      <= is_lookup ? EW'(r_nfw) : '0;
                r_res_status <= ST_RANGE;
            end else begin
                r_res_w      <= '0;
                r_res_status <= ST_SELF_LOOP;
            end
        end else if (i_cmd.hit) begin
            r_res_w      <= is_lookup ? EW'(r_hit_w) : EW'(new_w);
            r_res_found  <= 1'b1;
            r_res_status <= ST_OK;
        end else if (i_cmd.miss) begin
            r_res_found <= 1'b0;
            if (is_lookup) begin
                r_res_w      <= EW'(r_nfw);
                r_res_status <= ST_OK;
            end else if (row_full) begin
                r_res_w      <= '0;
                r_res_status <= ST_ROW_FULL;
            end else begin
                r_res_w      <= EW'(r_w);
                r_res_status <= ST_OK;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_w      <= out_sat_e[WORD_W-1:0];
            r_out_found  <= r_res_found;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_weight_out = r_out_w;
    assign o_found      = r_out_found;
    assign o_status     = r_out_status;

    // status to controller
    assign o_stat.range_bad = range_bad;
    assign o_stat.self_add  = self_add;
    assign o_stat.hit       = hit;
    assign o_stat.miss      = miss;
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

@@ hdl/weighted_edge_table.sv @@
// weighted_edge_table: top level of the weighted directed edge table
// depends on wet_pkg, wet_ctrl and wet_dpath
`default_nettype none

// Each source node owns a row of MAX_DEGREE slots (target, weight). Opcode 0
// adds an edge or replaces its weight, opcode 1 adds to the weight with
// saturation, opcodes 2 and 3 look it up. One word in gives one result word.
// Words are processed one at a time. Each passes through the check, the
// degree read, the row scan through the slot memory (one slot per cycle
// until the target is found or the end of the row is seen), the hit or
// miss step and the output step; an out-of-range node or a self-loop add
// goes from the check straight to the output step. A finished result waits
// in the output register while the next word is accepted; a result still
// waiting there when the next one is done holds the block in its output
// step until it is taken. No clearing pass is needed after reset.
// not_found_weight may be written only while the block is idle.
module weighted_edge_table
    import wet_pkg::*;
#(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int MAX_DEGREE  = MAX_DEGREE_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic signed [WORD_W-1:0]  i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [OP_W-1:0]           i_opcode,
    input  wire logic [NODE_W-1:0]         i_source_node,
    input  wire logic [NODE_W-1:0]         i_target_node,
    input  wire logic signed [WORD_W-1:0]  i_edge_weight_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [WORD_W-1:0]       o_weight_out,
    output logic                           o_found,
    output logic [STATUS_W-1:0]            o_status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    wet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // storage and arithmetic
    wet_dpath #(
        .NODE_COUNT  (NODE_COUNT),
        .MAX_DEGREE  (MAX_DEGREE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_opcode         (i_opcode),
        .i_source_node    (i_source_node),
        .i_target_node    (i_target_node),
        .i_edge_weight_in (i_edge_weight_in),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_weight_out     (o_weight_out),
        .o_found          (o_found),
        .o_status         (o_status),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat)
    );

    // a new word never enters in the cycle right after one was taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("word accepted while previous one still in work");

    // a result is published only into a free output register
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.publish |-> (!o_out_valid || i_out_ready))
        else $error("result published over a waiting result");

    // an existing edge is only reported with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == ST_OK))
        else $error("found flag set with error status");

    // ignored adds return a zero weight
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_SELF_LOOP || o_status == ST_ROW_FULL))
            |-> (o_weight_out == '0))
        else $error("rejected add returned a nonzero weight");

endmodule

`default_nettype wire
